### hw/rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants and types for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Default capacities of the pending window and of the replacement.
  localparam int DEF_MAX_PATTERN     = 8;
  localparam int DEF_MAX_REPLACEMENT = 8;

  // Width of the configuration register index.
  localparam int CFG_IDX_W = 8;

  // Width of the packed byte registers.
  localparam int CFG_DATA_W = 64;

  // Configuration register map.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 8'd0,
    REG_PATTERN_LENGTH     = 8'd1,
    REG_REPLACEMENT_BYTES  = 8'd2,
    REG_REPLACEMENT_LENGTH = 8'd3
  } sfr_reg_t;

  // Flags that travel with one burst of results.
  typedef struct packed {
    logic marker;  // burst is a single end marker without a byte
    logic last;    // final result of the burst closes the text
  } sfr_flags_t;

endpackage

### hw/rtl/sfr_matcher.sv
// ----------------------------------------------------------------------------
// sfr_matcher
// Pending byte window, pattern compare and burst descriptor for one word.
// ----------------------------------------------------------------------------
module sfr_matcher #(
  parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT,
  localparam int MAX_OUT = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT,
  localparam int FILL_W  = $clog2(MAX_PATTERN + 1),
  localparam int RL_W    = $clog2(MAX_REPLACEMENT + 1),
  localparam int CNT_W   = $clog2(MAX_OUT + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                clear_fill,
  input  logic                                fire,
  input  logic [7:0]                          text_byte,
  input  logic                                byte_present,
  input  logic                                text_end,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]      pattern_bytes,
  input  logic [FILL_W-1:0]                   pat_len,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]      replacement_bytes,
  input  logic [RL_W-1:0]                     rep_len,
  output logic [MAX_OUT-1:0][7:0]             burst_bytes,
  output logic [CNT_W-1:0]                    burst_count,
  output sfr_pkg::sfr_flags_t                 burst_flags
);
  import sfr_pkg::*;

  localparam int PAD_W = 8 * MAX_OUT;

  logic [7:0]                  window [MAX_PATTERN];
  logic [7:0]                  window_next [MAX_PATTERN];
  logic [7:0]                  win_a [MAX_PATTERN];
  logic [FILL_W-1:0]           fill;
  logic [FILL_W-1:0]           fill_next;
  logic [FILL_W-1:0]           fill_a;
  logic                        full;
  logic                        hit;
  logic [PAD_W+CFG_DATA_W-1:0] pat_pad;
  logic [PAD_W+CFG_DATA_W-1:0] rep_pad;

  // Byte positions beyond the packed registers read as zero.
  assign pat_pad = {{PAD_W{1'b0}}, pattern_bytes};
  assign rep_pad = {{PAD_W{1'b0}}, replacement_bytes};

  always_comb begin
    // Window with the incoming byte appended at the fill position.
    for (int i = 0; i < MAX_PATTERN; i++) begin
      win_a[i] = window[i];
      if (byte_present && fill == FILL_W'(i)) begin
        win_a[i] = text_byte;
      end
    end
    fill_a = fill + FILL_W'(byte_present);
    full   = byte_present && (fill_a >= pat_len);

    hit = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (FILL_W'(i) < pat_len && win_a[i] != pat_pad[8*i +: 8]) begin
        hit = 1'b0;
      end
    end

    burst_bytes = '0;
    burst_count = '0;
    burst_flags = '0;
    burst_flags.last = text_end;
    window_next = win_a;
    fill_next   = fill_a;

    if (full && hit) begin
      // Match: emit the replacement and drop the whole window.
      for (int i = 0; i < MAX_OUT; i++) begin
        burst_bytes[i] = rep_pad[8*i +: 8];
      end
      burst_count = CNT_W'(rep_len);
      fill_next   = '0;
    end else begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
        burst_bytes[i] = win_a[i];
      end
      if (text_end) begin
        // Flush everything that is pending, oldest first.
        burst_count = CNT_W'(fill_a);
        fill_next   = '0;
      end else if (full) begin
        // Mismatch on a full window: release the oldest byte and slide.
        burst_count = CNT_W'(1);
        fill_next   = fill_a - FILL_W'(1);
        for (int i = 0; i < MAX_PATTERN - 1; i++) begin
          window_next[i] = win_a[i+1];
        end
      end
    end

    // The end of a text always carries at least one result.
    if (text_end && burst_count == '0) begin
      burst_count        = CNT_W'(1);
      burst_flags.marker = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (clear_fill) begin
      fill <= '0;
    end else if (fire) begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      window <= window_next;
    end
  end

endmodule

### hw/rtl/stream_find_replace_all.sv
// ----------------------------------------------------------------------------
// stream_find_replace_all
// Streaming find-and-replace-all of a byte pattern with a byte replacement.
// ----------------------------------------------------------------------------
// Text words enter on the s_ side: s_tdata is the text byte, s_tuser says the
// byte is real (a word with s_tuser low only carries s_tlast or does nothing),
// and s_tlast closes the text. Results leave on the m_ side: m_tdata is the
// byte, m_tuser is high when it carries a byte and low for the end marker
// that closes a text which left nothing else to send, and m_tlast marks the
// final result of the text. Every greedy leftmost non-overlapping occurrence
// of the pattern is replaced; pending bytes are flushed at text end.
// The cfg_ port writes the pattern, the replacement and their lengths; it is
// always ready. It is to be written only while the block is idle; the block
// itself does not enforce this. Writing the pattern length drops any pending
// bytes. A word goes into an input register, is then matched against the
// window and its results land in a burst register, from which the output
// port offers them one at a time. One word is taken per cycle as long as each
// word yields at most one result and the receiver does not stall; a
// replacement or a flush of N bytes holds the input until the last of its
// bytes leaves the one-byte output port. When the receiver stalls, the burst
// register holds and the input register fills, then s_tready drops. Reset
// clears the window, the pipeline and the registers to their defaults.
// ----------------------------------------------------------------------------
module stream_find_replace_all #(
  parameter int MAX_PATTERN     = sfr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACEMENT = sfr_pkg::DEF_MAX_REPLACEMENT
) (
  input  logic                           clk,
  input  logic                           rst,
  // Text input.
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // [7:0] text_byte
  input  logic                           s_tuser,   // [0] byte_present
  input  logic                           s_tlast,   // text_end
  // Result output.
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // [7:0] out_byte
  output logic                           m_tuser,   // [0] out_valid
  output logic                           m_tlast,   // out_end
  // Configuration writes.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sfr_pkg::*;

  localparam int MAX_OUT = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
  localparam int FILL_W  = $clog2(MAX_PATTERN + 1);
  localparam int RL_W    = $clog2(MAX_REPLACEMENT + 1);
  localparam int CNT_W   = $clog2(MAX_OUT + 1);

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pattern_bytes;
  logic [3:0]            pattern_length;
  logic [CFG_DATA_W-1:0] replacement_bytes;
  logic [3:0]            replacement_length;
  logic [FILL_W-1:0]     pat_len;
  logic [RL_W-1:0]       rep_len;
  logic                  clear_fill;

  // Input register.
  logic                  in_valid;
  logic [7:0]            in_byte;
  logic                  in_present;
  logic                  in_end;

  // Burst register feeding the output port.
  logic [MAX_OUT-1:0][7:0] burst;
  logic [CNT_W-1:0]        burst_left;
  sfr_flags_t              flags;

  logic [MAX_OUT-1:0][7:0] match_bytes;
  logic [CNT_W-1:0]        match_count;
  sfr_flags_t              match_flags;
  logic                    load_ok;
  logic                    fire;

  assign cfg_ready  = 1'b1;
  assign clear_fill = cfg_valid && cfg_index == REG_PATTERN_LENGTH;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_bytes      <= '0;
      pattern_length     <= 4'd1;
      replacement_bytes  <= '0;
      replacement_length <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN_BYTES:      pattern_bytes      <= cfg_data;
        REG_PATTERN_LENGTH:     pattern_length     <= cfg_data[3:0];
        REG_REPLACEMENT_BYTES:  replacement_bytes  <= cfg_data;
        REG_REPLACEMENT_LENGTH: replacement_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // A zero pattern length acts as one; both lengths saturate at capacity.
  always_comb begin
    if (pattern_length == '0) begin
      pat_len = FILL_W'(1);
    end else if (int'(pattern_length) > MAX_PATTERN) begin
      pat_len = FILL_W'(MAX_PATTERN);
    end else begin
      pat_len = FILL_W'(pattern_length);
    end
    if (int'(replacement_length) > MAX_REPLACEMENT) begin
      rep_len = RL_W'(MAX_REPLACEMENT);
    end else begin
      rep_len = RL_W'(replacement_length);
    end
  end

  // A new burst may load when the current one is gone or leaves this cycle.
  assign load_ok  = (burst_left == '0) || (burst_left == CNT_W'(1) && m_tready);
  assign fire     = in_valid && load_ok;
  assign s_tready = !in_valid || load_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte    <= s_tdata;
      in_present <= s_tuser;
      in_end     <= s_tlast;
    end
  end

  sfr_matcher #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_matcher (
    .clk               (clk),
    .rst               (rst),
    .clear_fill        (clear_fill),
    .fire              (fire),
    .text_byte         (in_byte),
    .byte_present      (in_present),
    .text_end          (in_end),
    .pattern_bytes     (pattern_bytes),
    .pat_len           (pat_len),
    .replacement_bytes (replacement_bytes),
    .rep_len           (rep_len),
    .burst_bytes       (match_bytes),
    .burst_count       (match_count),
    .burst_flags       (match_flags)
  );

  // The burst drains from position zero; each taken word shifts it down.
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_left <= '0;
    end else if (fire) begin
      burst_left <= match_count;
    end else if (m_tready && burst_left != '0) begin
      burst_left <= burst_left - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      burst <= match_bytes;
      flags <= match_flags;
    end else if (m_tready && burst_left != '0) begin
      for (int i = 0; i < MAX_OUT - 1; i++) begin
        burst[i] <= burst[i+1];
      end
    end
  end

  assign m_tvalid = burst_left != '0;
  assign m_tdata  = flags.marker ? 8'h00 : burst[0];
  assign m_tuser  = !flags.marker;
  assign m_tlast  = flags.last && burst_left == CNT_W'(1);

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming find-and-replace-all block.
// ----------------------------------------------------------------------------
// A short table of directed words and register writes comes first: the reset
// defaults, deletion of a match, idle and end-only words, the end marker, an
// ignored register index, the longest pattern with the longest replacement,
// and a pattern length rewrite that drops pending bytes. Random texts follow,
// phase by phase under fresh register settings. Most of them are built from
// whole pattern copies, broken prefixes and bytes from the pattern's own
// alphabet, so matches are common. A predictor in this file tracks the window
// and the registers and queues the results that each accepted word owes.
// Every result word leaving the block is checked against the oldest of them.
// ----------------------------------------------------------------------------
module testbench;
  import sfr_pkg::*;

  // Index that no register answers to; a write to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;

  localparam int CLK_HALF      = 5;
  localparam int RANDOM_WORDS  = 320;
  // Input register, match stage and a full replacement burst, with margin.
  localparam int SETTLE_CYCLES = 12;
  // Cycles without any handshake before the run is declared hung.
  localparam int HANG_LIMIT    = 4000;
  localparam int IDLE_PCT      = 13;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;  // [7:0] text_byte
  logic                  s_tuser = 1'b0;   // [0] byte_present
  logic                  s_tlast = 1'b0;   // text_end
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [7:0]            m_tdata;          // [7:0] out_byte
  logic                  m_tuser;          // [0] out_valid
  logic                  m_tlast;          // out_end
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  stream_find_replace_all DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // One result word as the block should send it.
  typedef struct packed {
    logic [7:0] data;
    logic       carries;  // a real byte rather than the end marker
    logic       closes;   // last word of the text
  } result_t;

  // One row of the directed table: a register write or a text word. Rows
  // marked typed carry their expected outcome (none or one result word).
  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] value;
    logic [7:0]            text;
    logic                  present;
    logic                  fin;
    logic                  typed;
    logic                  typed_one;
    result_t               typed_res;
  } step_t;

  result_t due_results[$];
  step_t   plan[$];
  logic [7:0] text_buf[$];

  // Shadow of the block: registers and the window of pending text bytes.
  logic [63:0] pat_bytes = '0;
  logic [3:0]  pat_len = 4'd1;
  logic [63:0] rep_bytes = '0;
  logic [3:0]  rep_len = 4'd0;
  logic [7:0]  pending[8];
  int          pending_cnt = 0;
  int          last_made = 0;  // result words owed by the latest word

  int  mismatches = 0;
  int  words_sent = 0;
  int  hang_cycles = 0;
  bit  steady = 1'b0;  // both sides run without idling while set

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void owe(input logic [7:0] data, input logic carries);
    due_results.push_back('{data: data, carries: carries, closes: 1'b0});
  endfunction

  // Applies one accepted text word to the shadow window and queues the
  // result words it causes, in order.
  function automatic void scan_text(input logic [7:0] text, input logic present,
                                    input logic fin);
    int  plen;
    int  rlen;
    int  made;
    bit  hit;
    plen = (pat_len == 0) ? 1 : ((pat_len > 8) ? 8 : int'(pat_len));
    rlen = (rep_len > 8) ? 8 : int'(rep_len);
    made = 0;
    if (present) begin
      if (pending_cnt < 8) begin
        pending[pending_cnt] = text;
        pending_cnt++;
      end
      if (pending_cnt >= plen) begin
        hit = 1'b1;
        for (int i = 0; i < plen; i++)
          if (pending[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
        if (hit) begin
          // The whole window is consumed by the match.
          for (int i = 0; i < rlen; i++) begin
            owe(rep_bytes[8*i +: 8], 1'b1);
            made++;
          end
          pending_cnt = 0;
        end else begin
          // No match at this position: the oldest byte moves on unchanged.
          owe(pending[0], 1'b1);
          made++;
          for (int i = 0; i < 7; i++) pending[i] = pending[i+1];
          pending_cnt--;
        end
      end
    end
    if (fin) begin
      // Too few bytes remain for a match, so they leave as they are.
      for (int i = 0; i < pending_cnt; i++) begin
        owe(pending[i], 1'b1);
        made++;
      end
      pending_cnt = 0;
      if (made == 0) begin
        owe(8'h00, 1'b0);
        made++;
      end
      due_results[due_results.size()-1].closes = 1'b1;
    end
    last_made = made;
  endfunction

  function automatic void note_register(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_PATTERN_BYTES:      pat_bytes = value;
      REG_PATTERN_LENGTH: begin
        pat_len = value[3:0];
        pending_cnt = 0;
      end
      REG_REPLACEMENT_BYTES:  rep_bytes = value;
      REG_REPLACEMENT_LENGTH: rep_len = value[3:0];
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // Holds the sender until every owed result has left, then lets the
  // pipeline empty of words that owe nothing.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    note_register(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one text word, with a random gap in front of it, and books its
  // results at the edge where it is taken.
  task automatic send_word(input logic [7:0] text, input logic present,
                           input logic fin);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= text;
    s_tuser  <= present;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    scan_text(text, present, fin);
    if (present || fin) words_sent++;
  endtask

  function automatic logic [7:0] alphabet_byte();
    return pat_bytes[8*$urandom_range(0, int'(pat_len) - 1) +: 8];
  endfunction

  // Builds one random text, mostly from whole pattern copies, broken
  // prefixes and pattern bytes, and sends it with its end mark.
  task automatic send_text();
    int segs;
    int cut;
    bit end_on_byte;
    text_buf.delete();
    segs = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    for (int k = 0; k < segs; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          for (int j = 0; j < int'(pat_len); j++) text_buf.push_back(pat_bytes[8*j +: 8]);
        end
        5, 6: begin
          cut = $urandom_range(1, int'(pat_len));
          for (int j = 0; j < cut; j++) text_buf.push_back(pat_bytes[8*j +: 8]);
        end
        default: begin
          cut = $urandom_range(1, 3);
          for (int j = 0; j < cut; j++)
            text_buf.push_back(($urandom_range(0, 9) < 6) ? alphabet_byte()
                                                           : 8'($urandom_range(0, 255)));
        end
      endcase
    end
    end_on_byte = (text_buf.size() != 0) && ($urandom_range(0, 1) == 1);
    for (int j = 0; j < text_buf.size(); j++) begin
      // Now and then a word that carries neither a byte nor the end.
      if ($urandom_range(0, 9) == 0) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_word(text_buf[j], 1'b1, end_on_byte && (j == text_buf.size() - 1));
    end
    if (!end_on_byte) send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic random_settings();
    logic [63:0] pat;
    logic [63:0] rep;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    for (int k = 0; k < 8; k++) begin
      pat[8*k +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'h61 + 8'($urandom_range(0, 2));
      rep[8*k +: 8] = 8'($urandom_range(0, 255));
    end
    case ($urandom_range(0, 9))
      0, 1:    plen = 4'd8;
      2:       plen = 4'd1;
      default: plen = 4'($urandom_range(1, 4));
    endcase
    case ($urandom_range(0, 6))
      0:       rlen = 4'd0;
      1:       rlen = 4'd8;
      default: rlen = 4'($urandom_range(0, 8));
    endcase
    if ($urandom_range(0, 9) < 7) write_reg(REG_PATTERN_BYTES, pat);
    if ($urandom_range(0, 9) < 7) write_reg(REG_PATTERN_LENGTH, {60'd0, plen});
    if ($urandom_range(0, 9) < 7) write_reg(REG_REPLACEMENT_BYTES, rep);
    if ($urandom_range(0, 9) < 7) write_reg(REG_REPLACEMENT_LENGTH, {60'd0, rlen});
  endtask

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] value);
    step_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.idx    = idx;
    row.value  = value;
    return row;
  endfunction

  function automatic step_t text_row(input logic [7:0] text, input logic present,
                                     input logic fin);
    step_t row;
    row = '0;
    row.text    = text;
    row.present = present;
    row.fin     = fin;
    return row;
  endfunction

  function automatic step_t typed_row(input logic [7:0] text, input logic present,
                                      input logic fin, input logic one,
                                      input result_t res);
    step_t row;
    row = text_row(text, present, fin);
    row.typed     = 1'b1;
    row.typed_one = one;
    row.typed_res = res;
    return row;
  endfunction

  task automatic build_plan();
    // Reset defaults: one-byte pattern 00, empty replacement.
    plan.push_back(typed_row(8'h41, 1'b1, 1'b0, 1'b1, '{8'h41, 1'b1, 1'b0}));
    plan.push_back(typed_row(8'h00, 1'b1, 1'b0, 1'b0, '0));  // match, deleted
    plan.push_back(typed_row(8'h5A, 1'b0, 1'b0, 1'b0, '0));  // idle word
    plan.push_back(typed_row(8'hC3, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}));
    plan.push_back(typed_row(8'hFF, 1'b1, 1'b1, 1'b1, '{8'hFF, 1'b1, 1'b1}));
    // Pattern "abc" becomes "XY"; the text ends with a partial copy.
    plan.push_back(cfg_row(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261));
    plan.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd3));
    plan.push_back(cfg_row(REG_REPLACEMENT_BYTES, 64'h0000_0000_0000_5958));
    plan.push_back(cfg_row(REG_REPLACEMENT_LENGTH, 64'd2));
    plan.push_back(text_row(8'h78, 1'b1, 1'b0));
    plan.push_back(text_row(8'h61, 1'b1, 1'b0));
    plan.push_back(text_row(8'h62, 1'b1, 1'b0));
    plan.push_back(text_row(8'h63, 1'b1, 1'b0));
    plan.push_back(text_row(8'h61, 1'b1, 1'b0));
    plan.push_back(text_row(8'h62, 1'b1, 1'b1));
    // A write to an unmapped index leaves the settings alone.
    plan.push_back(cfg_row(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(text_row(8'h61, 1'b1, 1'b0));
    plan.push_back(text_row(8'h62, 1'b1, 1'b0));
    plan.push_back(text_row(8'h63, 1'b1, 1'b1));
    // Longest pattern, longest replacement.
    plan.push_back(cfg_row(REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF));
    plan.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd8));
    plan.push_back(cfg_row(REG_REPLACEMENT_BYTES, 64'hFF00_7F80_0102_40C3));
    plan.push_back(cfg_row(REG_REPLACEMENT_LENGTH, 64'd8));
    for (int k = 0; k < 8; k++) plan.push_back(text_row(8'hFF, 1'b1, 1'b0));
    // Two pending bytes are dropped by the length rewrite, so the end-only
    // word that follows closes an empty text with the marker.
    plan.push_back(text_row(8'h00, 1'b1, 1'b0));
    plan.push_back(text_row(8'h7F, 1'b1, 1'b0));
    plan.push_back(cfg_row(REG_PATTERN_LENGTH, 64'd1));
    plan.push_back(typed_row(8'h00, 1'b0, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}));
  endtask

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (due_results.size() == 0) begin
        $display("%0t: result word with none owed: data=%h user=%b last=%b",
                 $time, m_tdata, m_tuser, m_tlast);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        if (m_tdata !== want.data) begin
          $display("%0t: out_byte expected %h actual %h", $time, want.data, m_tdata);
          mismatches++;
        end
        if (m_tuser !== want.carries) begin
          $display("%0t: out_valid expected %b actual %b", $time, want.carries, m_tuser);
          mismatches++;
        end
        if (m_tlast !== want.closes) begin
          $display("%0t: out_end expected %b actual %b", $time, want.closes, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // The receiver stalls at random except during the steady stretch.
  always @(posedge clk) m_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

  // A run in which no word moves for too long has hung.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      hang_cycles <= 0;
    else if (hang_cycles >= HANG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, HANG_LIMIT);
      $display("testbench: FAIL");
      $finish;
    end else
      hang_cycles <= hang_cycles + 1;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    build_plan();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        // Registers change only once the block has gone quiet.
        wait_idle();
        write_reg(plan[i].idx, plan[i].value);
      end else begin
        send_word(plan[i].text, plan[i].present, plan[i].fin);
        if (plan[i].typed) begin
          // Swap the predicted results of this word for the typed ones.
          repeat (last_made) void'(due_results.pop_back());
          if (plan[i].typed_one) due_results.push_back(plan[i].typed_res);
        end
      end
    end

    // Random phases: new settings, then a few texts under them.
    words_sent = 0;
    while (words_sent < RANDOM_WORDS) begin
      wait_idle();
      random_settings();
      repeat ($urandom_range(1, 4)) begin
        steady = (words_sent >= 120) && (words_sent < 200);
        send_text();
      end
    end
    steady = 1'b0;

    wait_idle();
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

### sim.f
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_matcher.sv
hw/rtl/stream_find_replace_all.sv
bench/testbench.sv
